// ===== hw/rtl/ile_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Request codes, status codes, fixed field widths and the per-cell control
// group that the top level broadcasts along the cell chain.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int CAPACITY_DEF = 64;

    localparam int REQ_W    = 4;
    localparam int POS_W    = 7;
    localparam int POS2_W   = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_BACK  = 4'd0,
        REQ_PUSH_FRONT = 4'd1,
        REQ_POP_BACK   = 4'd2,
        REQ_POP_FRONT  = 4'd3,
        REQ_INSERT     = 4'd4,
        REQ_REMOVE     = 4'd5,
        REQ_READ       = 4'd6,
        REQ_WRITE      = 4'd7,
        REQ_SWAP       = 4'd8,
        REQ_CLEAR      = 4'd9
    } req_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // control broadcast to every cell at once
    typedef struct packed {
        logic sweep;       // advance the read lines one cell toward cell 0
        logic shift_up;    // cells above the index take the lower neighbor
        logic shift_down;  // cells at or above the index take the upper neighbor
        logic write_a;     // cell at the first index takes data a
        logic write_b;     // cell at the second index takes data b
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ile_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ile_cell: one list entry of the cell chain
// Holds one element and two read-line stages. Shifts take data from either
// neighbor; the read lines pass a matching element down toward cell 0.
// ----------------------------------------------------------------------------
module ile_cell #(
    parameter int INDEX = 0,
    parameter int CMP_W = 7
) (
    input  wire                         clk,
    input  wire ile_pkg::cell_ctrl_t    ctrl,
    input  wire [CMP_W-1:0]             pos_a,
    input  wire [CMP_W-1:0]             pos_b,
    input  wire [ile_pkg::DATA_W-1:0]   data_a,
    input  wire [ile_pkg::DATA_W-1:0]   data_b,
    input  wire [ile_pkg::DATA_W-1:0]   lower_data,
    input  wire [ile_pkg::DATA_W-1:0]   upper_data,
    input  wire [ile_pkg::DATA_W-1:0]   upper_rd_a,
    input  wire [ile_pkg::DATA_W-1:0]   upper_rd_b,
    output logic [ile_pkg::DATA_W-1:0]  data,
    output logic [ile_pkg::DATA_W-1:0]  rd_a,
    output logic [ile_pkg::DATA_W-1:0]  rd_b
);

    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [ile_pkg::DATA_W-1:0] data_reg, data_next;
    logic [ile_pkg::DATA_W-1:0] rd_a_reg, rd_a_next;
    logic [ile_pkg::DATA_W-1:0] rd_b_reg, rd_b_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_up)
        begin
            if (MY_IDX > pos_a)
                data_next = lower_data;
            else if (MY_IDX == pos_a)
                data_next = data_a;
        end
        if (ctrl.shift_down && (MY_IDX >= pos_a))
            data_next = upper_data;
        if (ctrl.write_a && (MY_IDX == pos_a))
            data_next = data_a;
        if (ctrl.write_b && (MY_IDX == pos_b))
            data_next = data_b;
    end

    always_comb
    begin
        rd_a_next = rd_a_reg;
        rd_b_next = rd_b_reg;
        if (ctrl.sweep)
        begin
            rd_a_next = (MY_IDX == pos_a) ? data_reg : upper_rd_a;
            rd_b_next = (MY_IDX == pos_b) ? data_reg : upper_rd_b;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        rd_a_reg <= rd_a_next;
        rd_b_reg <= rd_b_next;
    end

    assign data = data_reg;
    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/indexed_list_engine_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_engine_core: bounded ordered list in a chain of cells
// Insert, remove, push front and pop front move entries at once through
// neighbor links; read and swap fetch entries over a registered read line.
// ----------------------------------------------------------------------------
//  channel   ports                                        beat taken when
//  request   start, req_type, position, second_position,  start && !busy
//            value
//  result    done, read_value, status, count              done (one cycle)
//
//  Steps: accept, then apply; read and swap sweep the chain in between;
//  the read line walks the chain one cell per cycle toward cell 0.
//  The result strobe rises the cycle after apply; a new request may be
//  taken in that same cycle.
//  Reset clears the count and the control; entry contents stay unknown.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module indexed_list_engine_core #(
    parameter int CAPACITY = ile_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire [ile_pkg::REQ_W-1:0]            req_type,
    input  wire [ile_pkg::POS_W-1:0]            position,
    input  wire [ile_pkg::POS2_W-1:0]           second_position,
    input  wire signed [ile_pkg::DATA_W-1:0]    value,
    output logic                                done,
    output logic signed [ile_pkg::DATA_W-1:0]   read_value,
    output logic [ile_pkg::STATUS_W-1:0]        status,
    output logic [CNT_W-1:0]                    count
);

    localparam int CMP_W = (CNT_W > ile_pkg::POS_W) ? CNT_W : ile_pkg::POS_W;
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int DW    = ile_pkg::DATA_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_APPLY = 3'b100
    } state_t;

    typedef struct packed {
        logic sweep;
        logic shift_up;
        logic shift_down;
        logic write_a;
        logic write_b;
        logic rd_out;
        logic swap;
    } cmd_t;

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           sweep_cnt_reg, sweep_cnt_next;
    logic [CNT_W-1:0]           count_reg, count_next;
    logic [CNT_W-1:0]           new_cnt_reg, new_cnt_next;
    cmd_t                       cmd_reg, cmd_next;
    logic [ile_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [CMP_W-1:0]           addr_reg, addr_next;
    logic [CMP_W-1:0]           addr2_reg, addr2_next;
    logic [DW-1:0]              val_reg, val_next;
    logic                       done_reg, done_next;
    logic [ile_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [DW-1:0]              rdv_reg, rdv_next;

    logic                       accept;
    logic [CMP_W-1:0]           pos_x, pos2_x, cnt_x;
    logic                       full, empty;
    cmd_t                       cmd_d;
    logic [ile_pkg::STATUS_W-1:0] st_d;
    logic [CNT_W-1:0]           cnt_d;
    logic [CMP_W-1:0]           addr_d;

    ile_pkg::cell_ctrl_t        cell_ctrl;
    logic [DW-1:0]              data_a, data_b;
    logic [DW-1:0]              cell_data [CAPACITY];
    logic [DW-1:0]              cell_rd_a [CAPACITY];
    logic [DW-1:0]              cell_rd_b [CAPACITY];

    assign accept = start && !busy;
    assign pos_x  = CMP_W'(position);
    assign pos2_x = CMP_W'(second_position);
    assign cnt_x  = CMP_W'(count_reg);
    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);

    // decode the request against the current count
    always_comb
    begin
        cmd_d  = '0;
        st_d   = ile_pkg::ST_OK;
        cnt_d  = count_reg;
        addr_d = pos_x;
        unique case (req_type)
            ile_pkg::REQ_PUSH_BACK:
            begin
                addr_d = cnt_x;
                if (full)
                    st_d = ile_pkg::ST_FULL;
                else
                begin
                    cmd_d.write_a = 1'b1;
                    cnt_d = count_reg + CNT_W'(1);
                end
            end
            ile_pkg::REQ_PUSH_FRONT:
            begin
                addr_d = '0;
                if (full)
                    st_d = ile_pkg::ST_FULL;
                else
                begin
                    cmd_d.shift_up = 1'b1;
                    cnt_d = count_reg + CNT_W'(1);
                end
            end
            ile_pkg::REQ_POP_BACK:
            begin
                if (empty)
                    st_d = ile_pkg::ST_EMPTY;
                else
                    cnt_d = count_reg - CNT_W'(1);
            end
            ile_pkg::REQ_POP_FRONT:
            begin
                addr_d = '0;
                if (empty)
                    st_d = ile_pkg::ST_EMPTY;
                else
                begin
                    cmd_d.shift_down = 1'b1;
                    cnt_d = count_reg - CNT_W'(1);
                end
            end
            ile_pkg::REQ_INSERT:
            begin
                if (pos_x > cnt_x)
                    st_d = ile_pkg::ST_RANGE;
                else if (full)
                    st_d = ile_pkg::ST_FULL;
                else
                begin
                    cmd_d.shift_up = 1'b1;
                    cnt_d = count_reg + CNT_W'(1);
                end
            end
            ile_pkg::REQ_REMOVE:
            begin
                if (pos_x >= cnt_x)
                    st_d = ile_pkg::ST_RANGE;
                else
                begin
                    cmd_d.shift_down = 1'b1;
                    cnt_d = count_reg - CNT_W'(1);
                end
            end
            ile_pkg::REQ_READ:
            begin
                if (pos_x >= cnt_x)
                    st_d = ile_pkg::ST_RANGE;
                else
                begin
                    cmd_d.sweep  = 1'b1;
                    cmd_d.rd_out = 1'b1;
                end
            end
            ile_pkg::REQ_WRITE:
            begin
                if (pos_x >= cnt_x)
                    st_d = ile_pkg::ST_RANGE;
                else
                    cmd_d.write_a = 1'b1;
            end
            ile_pkg::REQ_SWAP:
            begin
                if ((pos_x >= cnt_x) || (pos2_x >= cnt_x))
                    st_d = ile_pkg::ST_RANGE;
                else
                begin
                    cmd_d.sweep   = 1'b1;
                    cmd_d.swap    = 1'b1;
                    cmd_d.write_a = 1'b1;
                    cmd_d.write_b = 1'b1;
                end
            end
            ile_pkg::REQ_CLEAR:
                cnt_d = '0;
            default:
                ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        sweep_cnt_next = sweep_cnt_reg;
        count_next     = count_reg;
        new_cnt_next   = new_cnt_reg;
        cmd_next       = cmd_reg;
        st_next        = st_reg;
        addr_next      = addr_reg;
        addr2_next     = addr2_reg;
        val_next       = val_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        rdv_next       = rdv_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = cmd_d;
                    st_next        = st_d;
                    new_cnt_next   = cnt_d;
                    addr_next      = addr_d;
                    addr2_next     = pos2_x;
                    val_next       = value;
                    sweep_cnt_next = IDX_W'(CAPACITY - 1);
                    state_next     = cmd_d.sweep ? S_SWEEP : S_APPLY;
                end
            end
            S_SWEEP:
            begin
                if (sweep_cnt_reg == '0)
                    state_next = S_APPLY;
                else
                    sweep_cnt_next = sweep_cnt_reg - IDX_W'(1);
            end
            S_APPLY:
            begin
                count_next  = new_cnt_reg;
                done_next   = 1'b1;
                status_next = st_reg;
                rdv_next    = cmd_reg.rd_out ? cell_rd_a[0] : '0;
                state_next  = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            cmd_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            cmd_reg    <= cmd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sweep_cnt_reg <= sweep_cnt_next;
        new_cnt_reg   <= new_cnt_next;
        st_reg        <= st_next;
        addr_reg      <= addr_next;
        addr2_reg     <= addr2_next;
        val_reg       <= val_next;
        status_reg    <= status_next;
        rdv_reg       <= rdv_next;
    end

    // broadcast to the chain; a swap writes each index with the other's entry
    always_comb
    begin
        cell_ctrl.sweep      = (state_reg == S_SWEEP);
        cell_ctrl.shift_up   = (state_reg == S_APPLY) && cmd_reg.shift_up;
        cell_ctrl.shift_down = (state_reg == S_APPLY) && cmd_reg.shift_down;
        cell_ctrl.write_a    = (state_reg == S_APPLY) && cmd_reg.write_a;
        cell_ctrl.write_b    = (state_reg == S_APPLY) && cmd_reg.write_b;
    end

    assign data_a = cmd_reg.swap ? cell_rd_b[0] : val_reg;
    assign data_b = cell_rd_a[0];

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [DW-1:0] lower_d, upper_d, upper_ra, upper_rb;
        if (k == 0)
        begin : g_first
            assign lower_d = '0;
        end
        else
        begin : g_lower
            assign lower_d = cell_data[k-1];
        end
        if (k == CAPACITY - 1)
        begin : g_last
            assign upper_d  = '0;
            assign upper_ra = '0;
            assign upper_rb = '0;
        end
        else
        begin : g_upper
            assign upper_d  = cell_data[k+1];
            assign upper_ra = cell_rd_a[k+1];
            assign upper_rb = cell_rd_b[k+1];
        end

        ile_cell #(
            .INDEX (k),
            .CMP_W (CMP_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .pos_a      (addr_reg),
            .pos_b      (addr2_reg),
            .data_a     (data_a),
            .data_b     (data_b),
            .lower_data (lower_d),
            .upper_data (upper_d),
            .upper_rd_a (upper_ra),
            .upper_rd_b (upper_rb),
            .data       (cell_data[k]),
            .rd_a       (cell_rd_a[k]),
            .rd_b       (cell_rd_b[k])
        );
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = rdv_reg;
    assign status     = status_reg;
    assign count      = count_reg;

    // the strobe follows an apply cycle and nothing else
    a_done_after_apply: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_APPLY))
        else $error("result strobe without apply");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("count above capacity");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ile_pkg::ST_OK)) |-> (read_value == '0))
        else $error("rejected request returned data");

    a_count_only_on_apply: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_APPLY) |=> $stable(count_reg))
        else $error("count changed outside apply");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for indexed_list_engine_core
// Drives list requests over the start/busy handshake and checks every done
// beat against an in-bench list predictor. A short directed table runs first,
// then phases of random requests that grow, drain or churn the list.
// ----------------------------------------------------------------------------
module tb;

    localparam int REQ_W    = ile_pkg::REQ_W;
    localparam int POS_W    = ile_pkg::POS_W;
    localparam int POS2_W   = ile_pkg::POS2_W;
    localparam int DATA_W   = ile_pkg::DATA_W;
    localparam int STATUS_W = ile_pkg::STATUS_W;

    localparam int LIST_CAP   = ile_pkg::CAPACITY_DEF;
    localparam int RAND_ITEMS = 800;
    localparam int STALL_MAX  = 2000;

    // request codes with no operation behind them
    localparam int REQ_UNUSED_FIRST = 10;
    localparam int REQ_UNUSED_LAST  = 15;

    // per-operation weights, index 0 is push back, index 8 is swap
    localparam logic [8:0][7:0] GROW_W  =
        {8'd4, 8'd4, 8'd8, 8'd4, 8'd4, 8'd6, 8'd20, 8'd15, 8'd30};
    localparam logic [8:0][7:0] DRAIN_W =
        {8'd6, 8'd6, 8'd8, 8'd16, 8'd14, 8'd20, 8'd8, 8'd6, 8'd16};
    localparam logic [8:0][7:0] CHURN_W =
        {8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10, 8'd10};

    typedef struct packed {
        logic signed [DATA_W-1:0] rd;
        logic [STATUS_W-1:0]      st;
        logic [POS_W-1:0]         cnt;
    } list_result_t;

    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [POS_W-1:0]  pos;
        logic [POS2_W-1:0] pos2;
        logic [DATA_W-1:0] val;
        int                reps;
        bit                typed;
        list_result_t      res;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [REQ_W-1:0] req_type = '0;
    logic [POS_W-1:0] position = '0;
    logic [POS2_W-1:0] second_position = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic busy;
    logic done;
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0] count;

    // predictor state
    logic signed [DATA_W-1:0] list_mem [0:LIST_CAP-1];
    int unsigned list_len;

    list_result_t pending_results[$];
    plan_row_t plan[$];

    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_full = 0;
    int n_empty = 0;
    int n_range = 0;
    int peak_len = 0;
    int stall_cycles = 0;
    bit idle_on = 1'b1;

    indexed_list_engine_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .position        (position),
        .second_position (second_position),
        .value           (value),
        .done            (done),
        .read_value      (read_value),
        .status          (status),
        .count           (count)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    function automatic list_result_t predict_request(input logic [REQ_W-1:0] kind,
                                                     input logic [POS_W-1:0] pos,
                                                     input logic [POS2_W-1:0] pos2,
                                                     input logic [DATA_W-1:0] val);
        list_result_t r;
        logic signed [DATA_W-1:0] tmp;
        int k;
        r.rd = '0;
        r.st = ile_pkg::ST_OK;
        case (ile_pkg::req_t'(kind))
            ile_pkg::REQ_PUSH_BACK:
                if (list_len >= LIST_CAP) r.st = ile_pkg::ST_FULL;
                else
                begin
                    list_mem[list_len] = val;
                    list_len++;
                end
            ile_pkg::REQ_PUSH_FRONT:
                if (list_len >= LIST_CAP) r.st = ile_pkg::ST_FULL;
                else
                begin
                    for (k = list_len; k > 0; k--) list_mem[k] = list_mem[k-1];
                    list_mem[0] = val;
                    list_len++;
                end
            ile_pkg::REQ_POP_BACK:
                if (list_len == 0) r.st = ile_pkg::ST_EMPTY;
                else list_len--;
            ile_pkg::REQ_POP_FRONT:
                if (list_len == 0) r.st = ile_pkg::ST_EMPTY;
                else
                begin
                    for (k = 0; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            ile_pkg::REQ_INSERT:
                if (pos > list_len) r.st = ile_pkg::ST_RANGE;
                else if (list_len >= LIST_CAP) r.st = ile_pkg::ST_FULL;
                else
                begin
                    for (k = list_len; k > pos; k--) list_mem[k] = list_mem[k-1];
                    list_mem[pos] = val;
                    list_len++;
                end
            ile_pkg::REQ_REMOVE:
                if (pos >= list_len) r.st = ile_pkg::ST_RANGE;
                else
                begin
                    for (k = pos; k + 1 < list_len; k++) list_mem[k] = list_mem[k+1];
                    list_len--;
                end
            ile_pkg::REQ_READ:
                if (pos >= list_len) r.st = ile_pkg::ST_RANGE;
                else r.rd = list_mem[pos];
            ile_pkg::REQ_WRITE:
                if (pos >= list_len) r.st = ile_pkg::ST_RANGE;
                else list_mem[pos] = val;
            ile_pkg::REQ_SWAP:
                if (pos >= list_len || pos2 >= list_len) r.st = ile_pkg::ST_RANGE;
                else
                begin
                    tmp = list_mem[pos];
                    list_mem[pos] = list_mem[pos2];
                    list_mem[pos2] = tmp;
                end
            ile_pkg::REQ_CLEAR:
                list_len = 0;
            default:
                ;
        endcase
        r.cnt = list_len[POS_W-1:0];
        return r;
    endfunction

    function automatic logic [REQ_W-1:0] pick_request(input int mode);
        logic [8:0][7:0] w;
        int total;
        int r;
        int k;
        w = (mode == 0) ? GROW_W : (mode == 1) ? DRAIN_W : CHURN_W;
        r = $urandom_range(99);
        // noise: unused codes and the odd clear
        if (r < 4)
            return REQ_W'(REQ_UNUSED_FIRST
                          + $urandom_range(REQ_UNUSED_LAST - REQ_UNUSED_FIRST));
        if (r < 6) return ile_pkg::REQ_CLEAR;
        total = 0;
        for (k = 0; k < 9; k++) total += w[k];
        r = $urandom_range(total - 1);
        for (k = 0; k < 9; k++)
        begin
            if (r < w[k]) return REQ_W'(k);
            r -= w[k];
        end
        return ile_pkg::REQ_SWAP;
    endfunction

    function automatic logic [POS_W-1:0] pick_index(input logic [REQ_W-1:0] kind);
        int hi;
        hi = (kind == ile_pkg::REQ_INSERT) ? list_len : list_len - 1;
        if (hi < 0 || $urandom_range(99) < 8) return POS_W'($urandom_range(127));
        return POS_W'($urandom_range(hi));
    endfunction

    task automatic idle_gap();
        if (idle_on)
        begin
            while ($urandom_range(99) < 35)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
    endtask

    task automatic send_request(input logic [REQ_W-1:0] kind,
                                input logic [POS_W-1:0] pos,
                                input logic [POS2_W-1:0] pos2,
                                input logic [DATA_W-1:0] val,
                                input bit typed,
                                input list_result_t typed_res);
        list_result_t exp_res;
        start           <= 1'b1;
        req_type        <= kind;
        position        <= pos;
        second_position <= pos2;
        value           <= val;
        do @(posedge clk); while (busy);
        // beat taken at this edge
        exp_res = predict_request(kind, pos, pos2, val);
        if (typed) exp_res = typed_res;
        pending_results.insert(pending_results.size(), exp_res);
        n_sent++;
        if (list_len > peak_len) peak_len = list_len;
    endtask

    task automatic add_row(input logic [REQ_W-1:0] kind, input int pos, input int pos2,
                           input logic [DATA_W-1:0] val, input int reps, input bit typed,
                           input logic [DATA_W-1:0] rd, input logic [STATUS_W-1:0] st,
                           input int cnt);
        plan_row_t row;
        row.kind   = kind;
        row.pos    = POS_W'(pos);
        row.pos2   = POS2_W'(pos2);
        row.val    = val;
        row.reps   = reps;
        row.typed  = typed;
        row.res.rd  = rd;
        row.res.st  = st;
        row.res.cnt = POS_W'(cnt);
        plan.insert(plan.size(), row);
    endtask

    task automatic build_plan();
        // empty list: every access is rejected
        add_row(ile_pkg::REQ_POP_BACK,   0, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_EMPTY, 0);
        add_row(ile_pkg::REQ_POP_FRONT,  0, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_EMPTY, 0);
        add_row(ile_pkg::REQ_READ,       0, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_RANGE, 0);
        add_row(ile_pkg::REQ_REMOVE,     0, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_RANGE, 0);
        add_row(ile_pkg::REQ_WRITE,      0, 0, 32'h1, 1, 1, 32'h0, ile_pkg::ST_RANGE, 0);
        add_row(ile_pkg::REQ_SWAP,       0, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_RANGE, 0);
        add_row(ile_pkg::REQ_INSERT,     1, 0, 32'h2, 1, 1, 32'h0, ile_pkg::ST_RANGE, 0);
        // value extremes at both ends
        add_row(ile_pkg::REQ_PUSH_BACK,  0, 0, 32'h7FFF_FFFF, 1, 1, 32'h0,
                ile_pkg::ST_OK, 1);
        add_row(ile_pkg::REQ_PUSH_FRONT, 0, 0, 32'h8000_0000, 1, 1, 32'h0,
                ile_pkg::ST_OK, 2);
        add_row(ile_pkg::REQ_READ,       0, 0, 32'h0, 1, 1, 32'h8000_0000,
                ile_pkg::ST_OK, 2);
        add_row(ile_pkg::REQ_READ,       1, 0, 32'h0, 1, 1, 32'h7FFF_FFFF,
                ile_pkg::ST_OK, 2);
        add_row(ile_pkg::REQ_INSERT,     2, 0, 32'hFFFF_FFFF, 1, 1, 32'h0,
                ile_pkg::ST_OK, 3);
        add_row(ile_pkg::REQ_INSERT,     1, 0, 32'h5555_5555, 1, 0, 32'h0,
                ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_WRITE,      3, 0, 32'hAAAA_AAAA, 1, 0, 32'h0,
                ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_SWAP,       0, 3, 32'h0, 1, 0, 32'h0, ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_SWAP,       2, 2, 32'h0, 1, 0, 32'h0, ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_READ,       3, 0, 32'h0, 1, 0, 32'h0, ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_REMOVE,     1, 0, 32'h0, 1, 0, 32'h0, ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_READ,     127, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_RANGE, 3);
        add_row(ile_pkg::REQ_SWAP,       0, 63, 32'h0, 1, 1, 32'h0, ile_pkg::ST_RANGE, 3);
        add_row(REQ_W'(REQ_UNUSED_LAST),  0, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_OK, 3);
        add_row(REQ_W'(REQ_UNUSED_FIRST), 0, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_OK, 3);
        add_row(ile_pkg::REQ_POP_FRONT,  0, 0, 32'h0, 1, 0, 32'h0, ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_POP_BACK,   0, 0, 32'h0, 1, 0, 32'h0, ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_CLEAR,      0, 0, 32'h0, 1, 1, 32'h0, ile_pkg::ST_OK, 0);
        // fill to the bound with random values, then hit it
        add_row(ile_pkg::REQ_PUSH_BACK,  0, 0, 32'h0, LIST_CAP, 0, 32'h0,
                ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_PUSH_BACK,  0, 0, 32'h3, 1, 1, 32'h0,
                ile_pkg::ST_FULL, LIST_CAP);
        add_row(ile_pkg::REQ_PUSH_FRONT, 0, 0, 32'h4, 1, 1, 32'h0,
                ile_pkg::ST_FULL, LIST_CAP);
        add_row(ile_pkg::REQ_INSERT, LIST_CAP, 0, 32'h5, 1, 1, 32'h0,
                ile_pkg::ST_FULL, LIST_CAP);
        add_row(ile_pkg::REQ_INSERT, LIST_CAP + 1, 0, 32'h6, 1, 1, 32'h0,
                ile_pkg::ST_RANGE, LIST_CAP);
        add_row(ile_pkg::REQ_READ, LIST_CAP - 1, 0, 32'h0, 1, 0, 32'h0,
                ile_pkg::ST_OK, 0);
        add_row(ile_pkg::REQ_REMOVE,     0, 0, 32'h0, 1, 0, 32'h0, ile_pkg::ST_OK, 0);
    endtask

    // check each done beat against the oldest expectation
    always @(posedge clk)
    begin
        list_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result read_value=%h status=%0d count=%0d",
                         $time, read_value, status, count);
                errors++;
            end
            else
            begin
                exp_res = pending_results[0];
                pending_results.delete(0);
                n_checked++;
                if (status == ile_pkg::ST_FULL) n_full++;
                if (status == ile_pkg::ST_EMPTY) n_empty++;
                if (status == ile_pkg::ST_RANGE) n_range++;
                if (read_value !== exp_res.rd)
                begin
                    $display("%0t: read_value expected %h actual %h",
                             $time, exp_res.rd, read_value);
                    errors++;
                end
                if (status !== exp_res.st)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.st, status);
                    errors++;
                end
                if (count !== exp_res.cnt)
                begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, exp_res.cnt, count);
                    errors++;
                end
            end
        end
    end

    // end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_MAX)
        begin
            $display("%0t: no progress for %0d cycles", $time, STALL_MAX);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        plan_row_t row;
        logic [REQ_W-1:0] kind;
        logic [POS2_W-1:0] pos2;
        int mode;
        int i;
        int j;

        list_len = 0;
        build_plan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < plan.size(); i++)
        begin
            row = plan[i];
            for (j = 0; j < row.reps; j++)
            begin
                idle_gap();
                send_request(row.kind, row.pos, row.pos2,
                             (row.reps > 1) ? DATA_W'($urandom) : row.val,
                             row.typed, row.res);
            end
        end

        mode = 0;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0) mode = $urandom_range(2);
            // hold start high back to back through this stretch
            idle_on = !(i >= 350 && i < 550);
            kind = pick_request(mode);
            if (kind == ile_pkg::REQ_SWAP && list_len > 0 && $urandom_range(99) >= 8)
                pos2 = POS2_W'($urandom_range(list_len - 1));
            else
                pos2 = POS2_W'($urandom_range(63));
            idle_gap();
            send_request(kind, pick_index(kind), pos2, DATA_W'($urandom), 1'b0, '0);
        end

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (LIST_CAP + 4) @(posedge clk);

        $display("Sent %0d requests, checked %0d results, peak list length %0d.",
                 n_sent, n_checked, peak_len);
        $display("Rejections seen: %0d full, %0d empty, %0d out of range.",
                 n_full, n_empty, n_range);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ile_pkg.sv
hw/rtl/ile_cell.sv
hw/rtl/indexed_list_engine_core.sv
bench/tb.sv
